// ===== rtl/wtog_pkg.sv =====
// ----------------------------------------------------------------------------
// wtog_pkg
// shared types and constants of the wavetable oscillator with glide and warp
// ----------------------------------------------------------------------------
`default_nettype none

package wtog_pkg;

  localparam int PH_BITS  = 24;
  localparam int TBL_BITS = 12;
  localparam int DIV_BITS = 24;
  localparam int DIV_NUM_W = 2 * DIV_BITS;

  localparam logic [PH_BITS-1:0] PH_HALF    = PH_BITS'(1) << (PH_BITS - 1);
  localparam logic [PH_BITS-1:0] PH_QUARTER = PH_BITS'(1) << (PH_BITS - 2);

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598669;
  localparam logic [30:0] SIN_C5  = 31'd85569304;
  localparam logic [30:0] SIN_C7  = 31'd5026995;
  localparam logic [30:0] SIN_C9  = 31'd172272;

  localparam logic signed [15:0] FULL_POS = 16'sd32767;
  localparam logic signed [15:0] FULL_NEG = -16'sd32767;

  typedef logic [1:0] wave_t;
  localparam wave_t WAVE_SINE   = 2'd0;
  localparam wave_t WAVE_TRI    = 2'd1;
  localparam wave_t WAVE_SQUARE = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WAVEFORM = 2'd0;
  localparam reg_idx_t REG_SHIFT    = 2'd1;
  localparam reg_idx_t REG_GLIDE    = 2'd2;

  localparam logic [16:0] SHIFT_MAX   = 17'd65536;
  localparam logic [16:0] SHIFT_RESET = 17'd32768;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_BITS-1:0]  den;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/wtog_ifs.sv =====
// ----------------------------------------------------------------------------
// wtog channel interfaces
// valid/ready channels for oscillator ticks and mixed samples
// ----------------------------------------------------------------------------
`default_nettype none

interface wtog_in_if;
  logic                valid;
  logic                ready;
  logic [3:0]          voice;
  logic [23:0]         target_increment;
  logic signed [23:0]  phase_mod;
  logic [15:0]         amp_gain;
  logic signed [15:0]  mix_in;

  modport source (output valid, voice, target_increment, phase_mod, amp_gain, mix_in,
                  input ready);
  modport sink (input valid, voice, target_increment, phase_mod, amp_gain, mix_in,
                output ready);
endinterface

interface wtog_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mix_out;

  modport source (output valid, mix_out, input ready);
  modport sink (input valid, mix_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/wtog_ram.sv =====
// ----------------------------------------------------------------------------
// wtog_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module wtog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ===== rtl/wtog_div.sv =====
// ----------------------------------------------------------------------------
// wtog_div
// restoring divider, one quotient bit per cycle, shared by glide and warp
// ----------------------------------------------------------------------------
`default_nettype none

module wtog_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire wtog_pkg::div_req_t       req,
  output logic                          done,
  output logic [wtog_pkg::DIV_BITS-1:0] quo
);
  import wtog_pkg::*;

  logic [DIV_BITS-1:0] rem_r, low_r, den_r, quo_r;
  logic [4:0]          cnt_r;
  logic                busy_r, done_r;
  logic [DIV_BITS:0]   trial, diff;
  logic                ge;

  // numerator's upper half is known to be below the divisor
  assign trial = {rem_r, low_r[DIV_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= req.num[DIV_NUM_W-1:DIV_BITS];
        low_r  <= req.num[DIV_BITS-1:0];
        den_r  <= req.den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        low_r <= {low_r[DIV_BITS-2:0], 1'b0};
        quo_r <= {quo_r[DIV_BITS-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

`default_nettype wire

// ===== rtl/wtog_shape.sv =====
// ----------------------------------------------------------------------------
// wtog_shape
// shape unit: sine polynomial sequencer, triangle and square at a warped phase
// ----------------------------------------------------------------------------
`default_nettype none

module wtog_shape (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire wtog_pkg::wave_t             wave,
  input  wire logic [wtog_pkg::PH_BITS-1:0] w,
  output logic                             done,
  output logic signed [15:0]               sample
);
  import wtog_pkg::*;

  typedef enum logic [1:0] {SH_IDLE, SH_MUL, SH_ACC} sh_state_t;

  sh_state_t          state_r;
  logic [2:0]         step_r;
  logic [30:0]        t_r, t2_r, acc_r;
  logic [1:0]         k_r;
  logic [61:0]        prod_r;
  logic               done_r;
  logic signed [15:0] sample_r;

  logic [TBL_BITS-1:0] idx, tri_o;
  logic [30:0]         t0, t_sel, op_a, op_b, x31;
  logic signed [14:0]  tri_d, tri_abs, tri_a;
  logic [12:0]         tri_m;
  logic [27:0]         tri_mq;
  logic [15:0]         tri_q;
  logic signed [15:0]  tri_s;
  logic [45:0]         sin_mm;
  logic [15:0]         sin_m;
  logic [14:0]         sin_c;
  logic signed [15:0]  sin_s;

  assign idx = w[PH_BITS-1 -: TBL_BITS];

  // quarter fold, angle in q30
  assign t0    = {1'b0, idx[TBL_BITS-3:0], 20'd0};
  assign t_sel = idx[TBL_BITS-2] ? (Q30_ONE - t0) : t0;

  // triangle, rounded half up on the magnitude
  assign tri_o   = idx + TBL_BITS'(3 << (TBL_BITS - 2));
  assign tri_d   = $signed({1'b0, tri_o, 2'b00}) - 15'sd8192;
  assign tri_abs = tri_d[14] ? -tri_d : tri_d;
  assign tri_a   = tri_abs - 15'sd4096;
  assign tri_m   = tri_a[14] ? 13'(-tri_a) : 13'(tri_a);
  assign tri_mq  = {tri_m, 15'd0} - 28'(tri_m) + 28'd2048;
  assign tri_q   = tri_mq[27:12];
  assign tri_s   = tri_a[14] ? -$signed(tri_q) : $signed(tri_q);

  always_comb begin
    case (step_r)
      3'd0: begin
        op_a = t_r;
        op_b = t_r;
      end
      3'd1: begin
        op_a = t2_r;
        op_b = SIN_C9;
      end
      3'd5: begin
        op_a = t_r;
        op_b = acc_r;
      end
      default: begin
        op_a = t2_r;
        op_b = acc_r;
      end
    endcase
  end

  assign x31 = prod_r[60:30];

  // scale to full scale, round half up, cap
  assign sin_mm = {x31, 15'd0} - 46'(x31) + 46'(32'h2000_0000);
  assign sin_m  = sin_mm[45:30];
  assign sin_c  = (sin_m > 16'd32767) ? 15'd32767 : sin_m[14:0];
  assign sin_s  = k_r[1] ? -$signed({1'b0, sin_c}) : $signed({1'b0, sin_c});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SH_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        SH_IDLE: begin
          if (start) begin
            case (wave)
              WAVE_SINE: begin
                t_r     <= t_sel;
                k_r     <= idx[TBL_BITS-1:TBL_BITS-2];
                step_r  <= '0;
                state_r <= SH_MUL;
              end
              WAVE_TRI: begin
                sample_r <= tri_s;
                done_r   <= 1'b1;
              end
              WAVE_SQUARE: begin
                sample_r <= (w < PH_HALF) ? FULL_POS : FULL_NEG;
                done_r   <= 1'b1;
              end
              default: begin
                sample_r <= '0;
                done_r   <= 1'b1;
              end
            endcase
          end
        end
        SH_MUL: begin
          prod_r  <= 62'(op_a) * 62'(op_b);
          state_r <= SH_ACC;
        end
        SH_ACC: begin
          step_r  <= step_r + 3'd1;
          state_r <= SH_MUL;
          case (step_r)
            3'd0: t2_r  <= x31;
            3'd1: acc_r <= SIN_C7 - x31;
            3'd2: acc_r <= SIN_C5 - x31;
            3'd3: acc_r <= SIN_C3 - x31;
            3'd4: acc_r <= SIN_C1 - x31;
            default: begin
              sample_r <= sin_s;
              done_r   <= 1'b1;
              state_r  <= SH_IDLE;
            end
          endcase
        end
        default: state_r <= SH_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign sample = sample_r;
endmodule

`default_nettype wire

// ===== rtl/wavetable_oscillator_glide_warp.sv =====
// ----------------------------------------------------------------------------
// wavetable_oscillator_glide_warp
// multi-voice oscillator with linear portamento and piecewise phase warp
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one sample tick for one voice; out_ch returns one mixed
//   sample per tick, in order. cfg_* is an apb-style register port (waveform
//   at 0x0, shift_amount at 0x4, glide_samples at 0x8), to be written by the
//   user only while the block is idle; the block itself does not enforce it.
//   per-voice phase and glide state sit in one ram read-modified-written once
//   per tick, so one tick is in flight at a time.
//   a silent tick (zero target or voice out of range) passes its mix through;
//   a sounding tick reads its voice state, runs the glide division when
//   glide_samples is non-zero, then the warp division for sine and triangle
//   (none for square or the unused shape code), the shape unit, gain and
//   write-back: the divider yields one quotient bit per cycle and the sine
//   polynomial runs six multiplies through one multiplier.
//   the input is taken again as soon as the sequencer returns to idle, even
//   while the previous result still waits in the output register; a stalled
//   receiver holds the result and the next tick then waits before write-back.
//   reset (synchronous, rst_n low) empties the output register, restores the
//   register defaults and marks every voice as zero state through valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator_glide_warp #(
  parameter int VOICE_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wtog_in_if.sink          in_ch,
  wtog_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import wtog_pkg::*;

  localparam int VAW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int RW  = 4 * PH_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_RD, S_GDIV, S_GFIN, S_WSET, S_WDIV,
    S_SSTART, S_SWAIT, S_GAIN, S_WB
  } state_t;

  // configuration registers
  wave_t       wave_r;
  logic [16:0] shift_r;
  logic [19:0] gs_r;

  state_t state_r;
  logic [VOICE_COUNT-1:0] vld_r;

  // latched tick
  logic [VAW-1:0]      vidx_r;
  logic [PH_BITS-1:0]  tgt_r, pm_r;
  logic [15:0]         gain_r;
  logic signed [15:0]  mix_r;

  // voice state under work
  logic [PH_BITS-1:0] phase_r, from_r, cur_r, targ_r, mag_r, w_r, base_r;
  logic               dneg_r, dnz_r;
  logic signed [15:0] sample_r;
  logic [30:0]        gprod_r;
  logic               gneg_r;

  logic               out_valid_r;
  logic signed [15:0] out_mix_r;

  // ram ports
  logic           ram_we;
  logic [RW-1:0]  ram_wdata, ram_rdata, rd_word;
  logic [VAW-1:0] ram_raddr;

  div_req_t           div_req;
  logic               div_done;
  logic [PH_BITS-1:0] div_quo;
  logic               shape_done;
  logic signed [15:0] shape_sample;

  logic cfg_wr, in_acc, in_range, out_free, out_load;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_WAVEFORM: cfg_prdata = {30'd0, wave_r};
      REG_SHIFT:    cfg_prdata = {15'd0, shift_r};
      REG_GLIDE:    cfg_prdata = {12'd0, gs_r};
      default:      cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign in_range       = (9'(in_ch.voice) < 9'(VOICE_COUNT));
  assign out_ch.valid   = out_valid_r;
  assign out_ch.mix_out = out_mix_r;
  assign out_free       = !out_valid_r || out_ch.ready;
  // output register loads on a pass-through or a write-back
  assign out_load       = ((state_r == S_PASS) || (state_r == S_WB)) && out_free;

  // the ram is read every cycle at the voice on the input channel
  assign ram_raddr = VAW'(in_ch.voice);

  wtog_ram #(.WIDTH(RW), .DEPTH(VOICE_COUNT)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vidx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wtog_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  wtog_shape u_shape (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_SSTART),
    .wave   (wave_r),
    .w      (w_r),
    .done   (shape_done),
    .sample (shape_sample)
  );

  // ---- read stage: a voice never written reads as all zero
  logic [PH_BITS-1:0] rd_phase, rd_from, rd_cur, rd_targ, g_cur, g_from, g_mag;
  logic               new_tgt;
  logic [PH_BITS:0]   g_d;

  assign rd_word  = vld_r[vidx_r] ? ram_rdata : '0;
  assign rd_phase = rd_word[4*PH_BITS-1 -: PH_BITS];
  assign rd_from  = rd_word[3*PH_BITS-1 -: PH_BITS];
  assign rd_cur   = rd_word[2*PH_BITS-1 -: PH_BITS];
  assign rd_targ  = rd_word[PH_BITS-1:0];

  // a new target restarts the glide from the increment in use,
  // a silent voice jumps straight to it
  assign new_tgt = (rd_targ != tgt_r);
  assign g_cur   = (new_tgt && rd_cur == '0) ? tgt_r : rd_cur;
  assign g_from  = new_tgt ? g_cur : rd_from;
  assign g_d     = {1'b0, tgt_r} - {1'b0, g_from};
  assign g_mag   = g_d[PH_BITS] ? PH_BITS'(-g_d) : g_d[PH_BITS-1:0];

  // ---- glide step, at least one lsb toward the target
  logic signed [PH_BITS+1:0] stp, ncur, tgt_s;
  logic [PH_BITS-1:0]        cur_nxt;

  assign stp   = dneg_r ? -$signed({2'b00, mag_r}) : $signed({2'b00, mag_r});
  assign ncur  = $signed({2'b00, cur_r}) + stp;
  assign tgt_s = $signed({2'b00, tgt_r});
  assign cur_nxt = ((stp < 0 && ncur > tgt_s) || (stp > 0 && ncur < tgt_s)) ?
                   ncur[PH_BITS-1:0] : tgt_r;

  // ---- warp setup: pick the segment, numerator, divisor and base
  logic [16:0]        sa;
  logic [PH_BITS-1:0] ws, wx, wden, wbase, wsq;
  logic [PH_BITS:0]   wlim;
  logic               warp_div;

  assign sa   = (shift_r > SHIFT_MAX) ? SHIFT_MAX : shift_r;
  assign ws   = PH_BITS'({sa, 7'd0});
  assign wlim = (PH_BITS+1)'({sa, 8'd0});
  assign wsq  = ({1'b0, phase_r} < wlim) ? '0 : PH_HALF;
  assign warp_div = (wave_r == WAVE_SINE) || (wave_r == WAVE_TRI);

  always_comb begin
    if (phase_r < ws) begin
      wx    = phase_r;
      wden  = ws;
      wbase = '0;
    end else if (phase_r < PH_HALF) begin
      wx    = phase_r - ws;
      wden  = PH_HALF - ws;
      wbase = PH_QUARTER;
    end else if ({1'b0, phase_r} < ((PH_BITS+1)'(1) << PH_BITS) - {1'b0, ws}) begin
      wx    = phase_r - PH_HALF;
      wden  = PH_HALF - ws;
      wbase = PH_HALF;
    end else begin
      // last segment, p - (one - s) with the wrap of the phase width
      wx    = phase_r + ws;
      wden  = ws;
      wbase = PH_HALF + PH_QUARTER;
    end
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_RD && gs_r != '0) begin
      div_req.start = 1'b1;
      div_req.num   = DIV_NUM_W'(g_mag);
      div_req.den   = DIV_BITS'(gs_r);
    end else if (state_r == S_WSET && warp_div) begin
      div_req.start = 1'b1;
      div_req.num   = DIV_NUM_W'({wx, 22'd0});
      div_req.den   = wden;
    end
  end

  // ---- gain, rounded half away from zero, then saturating mix
  logic [31:0]        g_rnd;
  logic signed [17:0] scaled;
  logic signed [18:0] sum;
  logic signed [15:0] sum_sat;

  assign g_rnd  = {1'b0, gprod_r} + 32'd16384;
  assign scaled = gneg_r ? -$signed({1'b0, g_rnd[31:15]}) : $signed({1'b0, g_rnd[31:15]});
  assign sum    = 19'(mix_r) + 19'(scaled);
  assign sum_sat = (sum > 19'sd32767)  ? 16'sd32767 :
                   (sum < -19'sd32768) ? -16'sd32768 : sum[15:0];

  assign ram_we    = (state_r == S_WB) && out_free;
  assign ram_wdata = {phase_r + cur_r + pm_r, from_r, cur_r, targ_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      wave_r      <= WAVE_SINE;
      shift_r     <= SHIFT_RESET;
      gs_r        <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_WAVEFORM: wave_r  <= cfg_pwdata[1:0];
          REG_SHIFT:    shift_r <= cfg_pwdata[16:0];
          REG_GLIDE:    gs_r    <= cfg_pwdata[19:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            vidx_r  <= VAW'(in_ch.voice);
            tgt_r   <= in_ch.target_increment;
            pm_r    <= in_ch.phase_mod;
            gain_r  <= in_ch.amp_gain;
            mix_r   <= in_ch.mix_in;
            state_r <= (in_range && in_ch.target_increment != '0) ? S_RD : S_PASS;
          end
        end
        S_PASS: begin
          // silent tick: mix passes through, state untouched
          if (out_free) begin
            out_mix_r <= mix_r;
            state_r   <= S_IDLE;
          end
        end
        S_RD: begin
          phase_r <= rd_phase;
          from_r  <= g_from;
          cur_r   <= g_cur;
          targ_r  <= tgt_r;
          dneg_r  <= g_d[PH_BITS];
          dnz_r   <= (g_d != '0);
          mag_r   <= '0;
          state_r <= (gs_r != '0) ? S_GDIV : S_GFIN;
        end
        S_GDIV: begin
          if (div_done) begin
            mag_r   <= (dnz_r && div_quo == '0) ? PH_BITS'(1) : div_quo;
            state_r <= S_GFIN;
          end
        end
        S_GFIN: begin
          cur_r   <= cur_nxt;
          state_r <= S_WSET;
        end
        S_WSET: begin
          base_r  <= wbase;
          w_r     <= wsq;
          state_r <= warp_div ? S_WDIV : S_SSTART;
        end
        S_WDIV: begin
          if (div_done) begin
            w_r     <= base_r + div_quo;
            state_r <= S_SSTART;
          end
        end
        S_SSTART: state_r <= S_SWAIT;
        S_SWAIT: begin
          if (shape_done) begin
            sample_r <= shape_sample;
            state_r  <= S_GAIN;
          end
        end
        S_GAIN: begin
          gprod_r <= 31'(sample_r[15] ? 16'(-sample_r) : 16'(sample_r)) * 31'(gain_r);
          gneg_r  <= sample_r[15];
          state_r <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            out_mix_r     <= sum_sat;
            vld_r[vidx_r] <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire
